/* hdl/pcapng_epb_framer_defines.svh */
// Assertion macros shared by the pcapng EPB framer RTL.
// Depends on nothing; the asserting scope must declare clk and rst_n.
`ifndef PCAPNG_EPB_FRAMER_DEFINES_SVH
`define PCAPNG_EPB_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define PEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PEF_ASSERT(lbl, prop, msg)
`define PEF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/pef_pkg.sv */
// Shared types and constants for the pcapng EPB framer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pef_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [1:0] REQ_HEADER = 2'd0;
  localparam logic [1:0] REQ_PACKET = 2'd1;
  localparam logic [1:0] REQ_NOTE   = 2'd2;

  localparam int unsigned TOTAL_W = 18;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_OPT,
    TAIL_CLOSE
  } tail_t;

  typedef struct packed {
    logic               has_hdr;
    logic               has_data;
    tail_t              tail;
    logic [31:0]        iface;
    logic [63:0]        stamp;
    logic [31:0]        wire_len;
    logic [15:0]        cap;
    logic [TOTAL_W-1:0] total;
    logic [15:0]        note;
    logic [31:0]        data;
  } desc_t;

endpackage

/* hdl/pef_core.sv */
// Block state tracking and byte packing for the pcapng EPB framer.
// Turns an accepted transaction into at most one descriptor; uses pef_pkg.
`timescale 1ns / 1ps
`include "pcapng_epb_framer_defines.svh"

module pef_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [1:0]          req_type,
  input  logic [31:0]         iface_index,
  input  logic [63:0]         stamp,
  input  logic [31:0]         wire_length,
  input  logic [15:0]         capture_length,
  input  logic [15:0]         note_length,
  input  logic [7:0]          data_byte,
  output logic                push,
  output pef_pkg::desc_t      desc
);

  localparam logic [pef_pkg::TOTAL_W-1:0] EPB_FIXED_BYTES = pef_pkg::TOTAL_W'(28);
  localparam logic [pef_pkg::TOTAL_W-1:0] WORD_BYTES      = pef_pkg::TOTAL_W'(4);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PACKET,
    PH_NOTE
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [pef_pkg::TOTAL_W-1:0]   block_total_r, block_total_nxt;
  logic [15:0]                   packet_left_r, packet_left_nxt;
  logic [15:0]                   note_left_r, note_left_nxt;
  logic [15:0]                   note_total_r, note_total_nxt;
  logic [23:0]                   gather_r, gather_nxt;
  logic [1:0]                    gather_cnt_r, gather_cnt_nxt;

  logic [15:0]                   pk_left;
  logic [15:0]                   nt_left;
  logic [31:0]                   packed_word;
  logic                          byte_last;
  logic                          byte_take;
  logic [1:0]                    cap_pad;
  logic [1:0]                    note_pad;
  logic [pef_pkg::TOTAL_W-1:0]   opt_len;
  logic [pef_pkg::TOTAL_W-1:0]   hdr_total;

  assign pk_left     = packet_left_r - 16'd1;
  assign nt_left     = note_left_r - 16'd1;
  assign packed_word = {8'h00, gather_r} | ({24'h000000, data_byte} << {gather_cnt_r, 3'b000});
  assign cap_pad     = 2'b00 - capture_length[1:0];
  assign note_pad    = 2'b00 - note_length[1:0];
  assign opt_len     = (note_length != 16'd0)
                     ? (WORD_BYTES + {2'b00, note_length} + {16'h0000, note_pad})
                     : '0;
  assign hdr_total   = EPB_FIXED_BYTES + {2'b00, capture_length} + {16'h0000, cap_pad}
                     + opt_len + WORD_BYTES + WORD_BYTES;

  always_comb begin
    phase_nxt       = phase_r;
    block_total_nxt = block_total_r;
    packet_left_nxt = packet_left_r;
    note_left_nxt   = note_left_r;
    note_total_nxt  = note_total_r;
    gather_nxt      = gather_r;
    gather_cnt_nxt  = gather_cnt_r;
    byte_take       = 1'b0;
    byte_last       = 1'b0;

    desc          = '0;
    desc.tail     = pef_pkg::TAIL_NONE;
    desc.iface    = iface_index;
    desc.stamp    = stamp;
    desc.wire_len = wire_length;
    desc.cap      = capture_length;
    desc.total    = block_total_r;
    desc.note     = note_total_r;
    desc.data     = packed_word;

    if (acc) begin
      case (req_type)
        pef_pkg::REQ_HEADER: begin
          desc.has_hdr    = 1'b1;
          desc.total      = hdr_total;
          desc.note       = note_length;
          block_total_nxt = hdr_total;
          packet_left_nxt = capture_length;
          note_total_nxt  = note_length;
          note_left_nxt   = 16'd0;
          gather_nxt      = 24'h000000;
          gather_cnt_nxt  = 2'd0;
          if (capture_length != 16'd0) begin
            phase_nxt = PH_PACKET;
          end else if (note_length != 16'd0) begin
            desc.tail     = pef_pkg::TAIL_OPT;
            note_left_nxt = note_length;
            phase_nxt     = PH_NOTE;
          end else begin
            desc.tail = pef_pkg::TAIL_CLOSE;
            phase_nxt = PH_IDLE;
          end
        end
        pef_pkg::REQ_PACKET: begin
          if (phase_r == PH_PACKET) begin
            byte_take       = 1'b1;
            byte_last       = (pk_left == 16'd0);
            packet_left_nxt = pk_left;
            if (byte_last) begin
              if (note_total_r != 16'd0) begin
                desc.tail     = pef_pkg::TAIL_OPT;
                note_left_nxt = note_total_r;
                phase_nxt     = PH_NOTE;
              end else begin
                desc.tail = pef_pkg::TAIL_CLOSE;
                phase_nxt = PH_IDLE;
              end
            end
          end
        end
        pef_pkg::REQ_NOTE: begin
          if (phase_r == PH_NOTE) begin
            byte_take     = 1'b1;
            byte_last     = (nt_left == 16'd0);
            note_left_nxt = nt_left;
            if (byte_last) begin
              desc.tail = pef_pkg::TAIL_CLOSE;
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase

      if (byte_take) begin
        if ((gather_cnt_r == 2'd3) || byte_last) begin
          desc.has_data  = 1'b1;
          gather_nxt     = 24'h000000;
          gather_cnt_nxt = 2'd0;
        end else begin
          gather_nxt     = packed_word[23:0];
          gather_cnt_nxt = gather_cnt_r + 2'd1;
        end
      end
    end

    push = desc.has_hdr || desc.has_data || (desc.tail != pef_pkg::TAIL_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      block_total_r <= '0;
      packet_left_r <= 16'd0;
      note_left_r   <= 16'd0;
      note_total_r  <= 16'd0;
      gather_r      <= 24'h000000;
      gather_cnt_r  <= 2'd0;
    end else begin
      phase_r       <= phase_nxt;
      block_total_r <= block_total_nxt;
      packet_left_r <= packet_left_nxt;
      note_left_r   <= note_left_nxt;
      note_total_r  <= note_total_nxt;
      gather_r      <= gather_nxt;
      gather_cnt_r  <= gather_cnt_nxt;
    end
  end

  `PEF_ASSERT(a_gather_in_block, (gather_cnt_r != 2'd0) |-> (phase_r != PH_IDLE), "partial word held while idle")
  `PEF_ASSERT(a_total_aligned, (block_total_r[1:0] == 2'b00), "block total not a multiple of four")
  `PEF_ASSERT(a_note_bounded, (phase_r == PH_NOTE) |-> (note_left_r != 16'd0), "comment phase with nothing left")

endmodule

/* hdl/pef_fifo.sv */
// Small descriptor queue between the state logic and the word serializer.
// Register array read at the head pointer; uses pef_pkg.
`timescale 1ns / 1ps
`include "pcapng_epb_framer_defines.svh"

module pef_fifo #(
  parameter int unsigned DEPTH = pef_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pef_pkg::desc_t wdata,
  output logic           full,
  input  logic           pop,
  output pef_pkg::desc_t rdata,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pef_pkg::desc_t     entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `PEF_ASSERT(a_no_overflow, push |-> !full, "push into a full queue")
  `PEF_ASSERT(a_no_underflow, pop |-> !empty, "pop from an empty queue")
  `PEF_ASSERT(a_count_bound, (count_r <= CNT_W'(DEPTH)), "queue count out of range")

endmodule

/* hdl/pef_emit.sv */
// pcapng EPB framer word serializer and output register; uses pef_pkg.
// Walks each queued descriptor one block word per cycle unless stalled.
`timescale 1ns / 1ps
`include "pcapng_epb_framer_defines.svh"

module pef_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  pef_pkg::desc_t head,
  input  logic           head_valid,
  output logic           pop,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [31:0]    out_word,
  output logic           out_block_end,
  output logic           out_run_last
);

  localparam logic [31:0] EPB_TYPE     = 32'h0000_0006;
  localparam logic [15:0] COMMENT_CODE = 16'h0001;

  typedef enum logic [3:0] {
    S_TYPE,
    S_TOTAL,
    S_IFACE,
    S_STAMP_HI,
    S_STAMP_LO,
    S_CAP,
    S_WIRE,
    S_DATA,
    S_OPT,
    S_EOO,
    S_TRAIL
  } step_t;

  step_t       step_r, step_nxt;
  logic        started_r, started_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        block_end_r, block_end_nxt;
  logic        run_last_r, run_last_nxt;

  step_t       first_step;
  step_t       cur_step;
  step_t       tail_step;
  step_t       follow_step;
  logic        tail_done;
  logic        done;
  logic        load;
  logic [31:0] cur_word;

  always_comb begin
    if (head.has_hdr) begin
      first_step = S_TYPE;
    end else if (head.has_data) begin
      first_step = S_DATA;
    end else if (head.tail == pef_pkg::TAIL_OPT) begin
      first_step = S_OPT;
    end else begin
      first_step = S_EOO;
    end
    cur_step = started_r ? step_r : first_step;

    tail_done = 1'b0;
    tail_step = S_EOO;
    case (head.tail)
      pef_pkg::TAIL_OPT:   tail_step = S_OPT;
      pef_pkg::TAIL_CLOSE: tail_step = S_EOO;
      default:             tail_done = 1'b1;
    endcase

    done        = 1'b0;
    follow_step = cur_step;
    unique case (cur_step)
      S_TYPE:     follow_step = S_TOTAL;
      S_TOTAL:    follow_step = S_IFACE;
      S_IFACE:    follow_step = S_STAMP_HI;
      S_STAMP_HI: follow_step = S_STAMP_LO;
      S_STAMP_LO: follow_step = S_CAP;
      S_CAP:      follow_step = S_WIRE;
      S_WIRE: begin
        if (head.has_data) begin
          follow_step = S_DATA;
        end else begin
          follow_step = tail_step;
          done        = tail_done;
        end
      end
      S_DATA: begin
        follow_step = tail_step;
        done        = tail_done;
      end
      S_OPT:   done = 1'b1;
      S_EOO:   follow_step = S_TRAIL;
      S_TRAIL: done = 1'b1;
      default: done = 1'b1;
    endcase

    unique case (cur_step)
      S_TYPE:     cur_word = EPB_TYPE;
      S_TOTAL:    cur_word = {{(32 - pef_pkg::TOTAL_W){1'b0}}, head.total};
      S_IFACE:    cur_word = head.iface;
      S_STAMP_HI: cur_word = head.stamp[63:32];
      S_STAMP_LO: cur_word = head.stamp[31:0];
      S_CAP:      cur_word = {16'h0000, head.cap};
      S_WIRE:     cur_word = head.wire_len;
      S_DATA:     cur_word = head.data;
      S_OPT:      cur_word = {head.note, COMMENT_CODE};
      S_EOO:      cur_word = 32'h0000_0000;
      S_TRAIL:    cur_word = {{(32 - pef_pkg::TOTAL_W){1'b0}}, head.total};
      default:    cur_word = 32'h0000_0000;
    endcase
  end

  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && done;

  always_comb begin
    step_nxt      = step_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    block_end_nxt = block_end_r;
    run_last_nxt  = run_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = cur_word;
      block_end_nxt = (cur_step == S_TRAIL);
      run_last_nxt  = done;
      started_nxt   = !done;
      step_nxt      = follow_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_TYPE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      block_end_r <= 1'b0;
      run_last_r  <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      block_end_r <= block_end_nxt;
      run_last_r  <= run_last_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign out_block_end = block_end_r;
  assign out_run_last  = run_last_r;

  `PEF_ASSERT(a_end_is_last, (out_valid_r && block_end_r) |-> run_last_r, "trailer not last of transaction")
  `PEF_ASSERT(a_end_aligned, (out_valid_r && block_end_r) |-> (out_word_r[1:0] == 2'b00), "trailer length misaligned")
  `PEF_ASSERT(a_started_head, started_r |-> head_valid, "walking a descriptor that is gone")

endmodule

/* hdl/pcapng_epb_framer.sv */
// pcapng Enhanced Packet Block framer, top level.
// Input channel (in_*): one transaction is a packet header, a packet byte or a comment byte,
// selected by in_req_type. Output channel (out_*): one 32-bit little-endian block word per
// transaction, with out_block_end on the trailing total length and out_run_last on the
// final word caused by one input transaction.
// A header yields seven to nine words, a byte yields none to three. Bytes that do not
// match the open block are dropped, and a header abandons any unfinished block.
// The first word of a transaction passes the descriptor queue and then the output register.
// Throughput: one input transaction per cycle is taken while the descriptor queue
// (FIFO_DEPTH entries) has room; the output register delivers one word per cycle while
// out_ready is high. When the receiver stalls, the output word holds and the queue fills;
// in_ready falls only when the queue is full. Synchronous reset empties the queue and
// the output register and returns the block to idle with all lengths cleared.
// Uses pef_pkg, pef_core, pef_fifo and pef_emit.
`timescale 1ns / 1ps

module pcapng_epb_framer #(
  parameter int unsigned FIFO_DEPTH = pef_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_iface_index,
  input  logic [63:0] in_stamp,
  input  logic [31:0] in_wire_length,
  input  logic [15:0] in_capture_length,
  input  logic [15:0] in_note_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        out_block_end,
  output logic        out_run_last
);

  logic           acc;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  pef_pkg::desc_t wdesc;
  pef_pkg::desc_t head;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  pef_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .req_type       (in_req_type),
    .iface_index    (in_iface_index),
    .stamp          (in_stamp),
    .wire_length    (in_wire_length),
    .capture_length (in_capture_length),
    .note_length    (in_note_length),
    .data_byte      (in_data_byte),
    .push           (push),
    .desc           (wdesc)
  );

  pef_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wdesc),
    .full  (full),
    .pop   (pop),
    .rdata (head),
    .empty (empty)
  );

  pef_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .head_valid    (!empty),
    .pop           (pop),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_word      (out_word),
    .out_block_end (out_block_end),
    .out_run_last  (out_run_last)
  );

endmodule
